/* src/promolecular_density_eval_defines.svh */
// ----------------------------------------------------------------------------
// promolecular density evaluator assertion macros
// shared concurrent assertion forms, clocked on clk and quiet during rst
// ----------------------------------------------------------------------------
`ifndef PROMOLECULAR_DENSITY_EVAL_DEFINES_SVH
`define PROMOLECULAR_DENSITY_EVAL_DEFINES_SVH

// condition holds at every edge
`define PDE_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define PDE_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

/* src/pde_pkg.sv */
// ----------------------------------------------------------------------------
// pde_pkg
// shared codes, command type and fixed element coefficient tables
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pde_pkg;

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_LOAD  = 2'd1;
  localparam logic [1:0] ACT_EVAL  = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  localparam logic [47:0] RHO_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [30:0] INV_E   = 31'd1580030169;
  localparam logic [4:0]  ELEM_N  = 5'd19;
  localparam int          ENTRY_W = 5 + 3 * 32;

  typedef enum logic [1:0] {
    CLS_CLEAR,
    CLS_LOAD,
    CLS_EVAL,
    CLS_NOP
  } cmd_cls_t;

  typedef struct packed {
    cmd_cls_t    cls;
    logic [4:0]  kind;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } cmd_t;

  // decimal scale per exponent, constants are m.mmmmmmm * 10^e
  localparam logic [63:0] SC   = 64'd16777216;
  localparam logic [63:0] D_N1 = 64'd100000000;
  localparam logic [63:0] D_0  = 64'd10000000;
  localparam logic [63:0] D_1  = 64'd1000000;
  localparam logic [63:0] D_2  = 64'd100000;
  localparam logic [63:0] D_3  = 64'd10000;
  localparam logic [63:0] D_4  = 64'd1000;

  // coefficients c in q24, rounded to nearest
  localparam logic [63:0] C_TAB [0:2][0:18] = '{
    '{64'd0,
      (64'd46568633 * SC + D_N1 / 2) / D_N1, (64'd19613583 * SC + D_1 / 2) / D_1,
      (64'd10682467 * SC + D_2 / 2) / D_2,   (64'd49307260 * SC + D_N1 / 2) / D_N1,
      (64'd25663419 * SC + D_2 / 2) / D_2,   (64'd40348178 * SC + D_2 / 2) / D_2,
      (64'd63406713 * SC + D_2 / 2) / D_2,   (64'd95831026 * SC + D_2 / 2) / D_2,
      (64'd16273443 * SC + D_1 / 2) / D_1,   (64'd19788394 * SC + D_3 / 2) / D_3,
      (64'd35289679 * SC + D_3 / 2) / D_3,   (64'd10046303 * SC + D_2 / 2) / D_2,
      (64'd62991738 * SC + D_3 / 2) / D_3,   (64'd84532518 * SC + D_3 / 2) / D_3,
      (64'd11107832 * SC + D_4 / 2) / D_4,   (64'd14348550 * SC + D_4 / 2) / D_4,
      (64'd60301596 * SC + D_2 / 2) / D_2,   (64'd80816108 * SC + D_2 / 2) / D_2},
    '{64'd0,
      (64'd46568622 * SC + D_N1 / 2) / D_N1, (64'd19568763 * SC + D_1 / 2) / D_1,
      (64'd10681231 * SC + D_2 / 2) / D_2,   (64'd52439107 * SC + D_0 / 2) / D_0,
      (64'd11256576 * SC + D_0 / 2) / D_0,   (64'd22620806 * SC + D_0 / 2) / D_0,
      (64'd63404543 * SC + D_2 / 2) / D_2,   (64'd89583281 * SC + D_0 / 2) / D_0,
      (64'd13870221 * SC + D_3 / 2) / D_3,   (64'd19614363 * SC + D_3 / 2) / D_3,
      (64'd35302178 * SC + D_3 / 2) / D_3,   (64'd45960222 * SC + D_3 / 2) / D_3,
      (64'd15274864 * SC + D_2 / 2) / D_2,   (64'd84342635 * SC + D_3 / 2) / D_3,
      (64'd31824165 * SC + D_2 / 2) / D_2,   (64'd44165626 * SC + D_2 / 2) / D_2,
      (64'd18325620 * SC + D_4 / 2) / D_4,   (64'd23005524 * SC + D_4 / 2) / D_4},
    '{64'd0,
      (64'd30019989 * SC + D_0 / 2) / D_0,   (64'd13983775 * SC + D_0 / 2) / D_0,
      (64'd33342545 * SC + D_1 / 2) / D_1,   (64'd31734662 * SC + D_2 / 2) / D_2,
      (64'd25867085 * SC + D_2 / 2) / D_2,   (64'd40837497 * SC + D_2 / 2) / D_2,
      (64'd46765606 * SC + D_0 / 2) / D_0,   (64'd95832030 * SC + D_2 / 2) / D_2,
      (64'd14029674 * SC + D_3 / 2) / D_3,   (64'd28279579 * SC + D_1 / 2) / D_1,
      (64'd74670217 * SC + D_1 / 2) / D_1,   (64'd46015044 * SC + D_3 / 2) / D_3,
      (64'd62957609 * SC + D_3 / 2) / D_3,   (64'd22368762 * SC + D_2 / 2) / D_2,
      (64'd11103799 * SC + D_4 / 2) / D_4,   (64'd14364194 * SC + D_4 / 2) / D_4,
      (64'd18305210 * SC + D_4 / 2) / D_4,   (64'd23084071 * SC + D_4 / 2) / D_4}
  };

  // exponents a in q24, rounded to nearest
  localparam logic [63:0] A_TAB [0:2][0:18] = '{
    '{64'd0,
      (64'd19888088 * SC + D_0 / 2) / D_0,   (64'd38987496 * SC + D_0 / 2) / D_0,
      (64'd62028021 * SC + D_0 / 2) / D_0,   (64'd72657186 * SC + D_N1 / 2) / D_N1,
      (64'd97173881 * SC + D_0 / 2) / D_0,   (64'd11698438 * SC + D_1 / 2) / D_1,
      (64'd13677050 * SC + D_1 / 2) / D_1,   (64'd15655698 * SC + D_1 / 2) / D_1,
      (64'd15948420 * SC + D_0 / 2) / D_0,   (64'd19625025 * SC + D_1 / 2) / D_1,
      (64'd22086110 * SC + D_1 / 2) / D_1,   (64'd26605426 * SC + D_0 / 2) / D_0,
      (64'd26057308 * SC + D_1 / 2) / D_1,   (64'd28120183 * SC + D_1 / 2) / D_1,
      (64'd30186892 * SC + D_1 / 2) / D_1,   (64'd32254026 * SC + D_1 / 2) / D_1,
      (64'd42979610 * SC + D_0 / 2) / D_0,   (64'd46484753 * SC + D_0 / 2) / D_0},
    '{64'd0,
      (64'd19888088 * SC + D_0 / 2) / D_0,   (64'd38982540 * SC + D_0 / 2) / D_0,
      (64'd62023193 * SC + D_0 / 2) / D_0,   (64'd41739221 * SC + D_0 / 2) / D_0,
      (64'd83058204 * SC + D_N1 / 2) / D_N1, (64'd96295177 * SC + D_N1 / 2) / D_N1,
      (64'd13677045 * SC + D_1 / 2) / D_1,   (64'd13642293 * SC + D_0 / 2) / D_0,
      (64'd17635609 * SC + D_1 / 2) / D_1,   (64'd19625014 * SC + D_1 / 2) / D_1,
      (64'd22085863 * SC + D_1 / 2) / D_1,   (64'd23998338 * SC + D_1 / 2) / D_1,
      (64'd29772425 * SC + D_0 / 2) / D_0,   (64'd28120238 * SC + D_1 / 2) / D_1,
      (64'd36228839 * SC + D_0 / 2) / D_0,   (64'd39540388 * SC + D_0 / 2) / D_0,
      (64'd34332866 * SC + D_1 / 2) / D_1,   (64'd36415201 * SC + D_1 / 2) / D_1},
    '{64'd0,
      (64'd19888228 * SC + D_0 / 2) / D_0,   (64'd16012664 * SC + D_0 / 2) / D_0,
      (64'd38061318 * SC + D_0 / 2) / D_0,   (64'd78497277 * SC + D_0 / 2) / D_0,
      (64'd97173599 * SC + D_0 / 2) / D_0,   (64'd11698438 * SC + D_1 / 2) / D_1,
      (64'd11538421 * SC + D_0 / 2) / D_0,   (64'd15655807 * SC + D_1 / 2) / D_1,
      (64'd17635595 * SC + D_1 / 2) / D_1,   (64'd18462843 * SC + D_0 / 2) / D_0,
      (64'd24886290 * SC + D_0 / 2) / D_0,   (64'd23998352 * SC + D_1 / 2) / D_1,
      (64'd26057363 * SC + D_1 / 2) / D_1,   (64'd32971353 * SC + D_0 / 2) / D_0,
      (64'd30186664 * SC + D_1 / 2) / D_1,   (64'd32254046 * SC + D_1 / 2) / D_1,
      (64'd34332897 * SC + D_1 / 2) / D_1,   (64'd36415230 * SC + D_1 / 2) / D_1}
  };

  // floor(2^32 / k) for the series divisors 1..14
  localparam logic [32:0] RECIP [0:15] = '{
    33'd0,
    33'(64'h1_0000_0000 / 64'd1),  33'(64'h1_0000_0000 / 64'd2),
    33'(64'h1_0000_0000 / 64'd3),  33'(64'h1_0000_0000 / 64'd4),
    33'(64'h1_0000_0000 / 64'd5),  33'(64'h1_0000_0000 / 64'd6),
    33'(64'h1_0000_0000 / 64'd7),  33'(64'h1_0000_0000 / 64'd8),
    33'(64'h1_0000_0000 / 64'd9),  33'(64'h1_0000_0000 / 64'd10),
    33'(64'h1_0000_0000 / 64'd11), 33'(64'h1_0000_0000 / 64'd12),
    33'(64'h1_0000_0000 / 64'd13), 33'(64'h1_0000_0000 / 64'd14),
    33'd0
  };

endpackage

`default_nettype wire

/* src/pde_ram.sv */
// ----------------------------------------------------------------------------
// pde_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* src/pde_front.sv */
// ----------------------------------------------------------------------------
// pde_front
// accepts items, decodes the action and queues commands for the back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pde_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output logic                    item_ready,
  input  wire logic [1:0]         action,
  input  wire logic [4:0]         atomic_number,
  input  wire logic signed [31:0] pos_x,
  input  wire logic signed [31:0] pos_y,
  input  wire logic signed [31:0] pos_z,
  output logic                    q_valid,
  output pde_pkg::cmd_t           q_cmd,
  input  wire logic               q_pop
);

  pde_pkg::cmd_t    slot [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;
  pde_pkg::cmd_cls_t cls;
  logic             push;

  always_comb begin
    case (action)
      pde_pkg::ACT_CLEAR: cls = pde_pkg::CLS_CLEAR;
      pde_pkg::ACT_LOAD:  cls = pde_pkg::CLS_LOAD;
      pde_pkg::ACT_EVAL:  cls = pde_pkg::CLS_EVAL;
      default:            cls = pde_pkg::CLS_NOP;
    endcase
  end

  assign item_ready = (fill != 2'd2);
  assign push       = item_valid && item_ready;
  assign q_valid    = (fill != 2'd0);
  assign q_cmd      = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= '{cls: cls, kind: atomic_number, x: pos_x, y: pos_y, z: pos_z};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, q_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

/* src/pde_back.sv */
// ----------------------------------------------------------------------------
// pde_back
// atom store and density sequencer around one shared multiplier
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "promolecular_density_eval_defines.svh"

module pde_back #(
  parameter int MAX_ATOMS = 256
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  pde_pkg::cmd_t      q_cmd,
  output logic               q_pop,
  output logic               result_valid,
  input  wire logic          result_ready,
  output logic [47:0]        rho,
  output logic [1:0]         status
);

  localparam int AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
  localparam int CW = $clog2(MAX_ATOMS + 1);
  localparam int EW = pde_pkg::ENTRY_W;

  typedef enum logic [17:0] {
    S_IDLE  = 18'h00001,
    S_FETCH = 18'h00002,
    S_DIFF  = 18'h00004,
    S_SQ    = 18'h00008,
    S_ROOT  = 18'h00010,
    S_TPROD = 18'h00020,
    S_TCHK  = 18'h00040,
    S_TMUL  = 18'h00080,
    S_TREC  = 18'h00100,
    S_TCOR  = 18'h00200,
    S_CLAMP = 18'h00400,
    S_SCALE = 18'h00800,
    S_SHIFT = 18'h01000,
    S_CLO   = 18'h02000,
    S_CHI   = 18'h04000,
    S_CADD  = 18'h08000,
    S_NEXT  = 18'h10000,
    S_DONE  = 18'h20000
  } state_t;

  state_t             state;
  logic [CW-1:0]      count;
  logic [CW-1:0]      idx;
  logic [CW-1:0]      idx_inc;
  logic [31:0]        px, py, pz;
  logic [4:0]         kind_r;
  logic [21:0]        d0, d1, d2;
  logic [21:0]        dsel;
  logic [1:0]         sq_cnt;
  logic [45:0]        r2;
  logic [45:0]        root_v, root_res, root_bit, root_sum, res_next;
  logic               root_ge;
  logic [22:0]        r;
  logic [1:0]         j;
  logic [5:0]         n;
  logic [31:0]        f;
  logic [32:0]        term, xq, q0, qk, rem, qv, e, e_clamp;
  logic signed [34:0] sum, sum_upd;
  logic [3:0]         kk;
  logic [44:0]        lo;
  logic [64:0]        csum;
  logic [48:0]        acc, acc_add;
  logic               sat;
  logic [32:0]        mul_a, mul_b;
  logic [65:0]        prod;
  logic [29:0]        aq;
  logic [38:0]        cq;
  logic               out_free, full, pop, ram_we;
  logic [EW-1:0]      rdata;
  logic [4:0]         rd_kind;
  logic [32:0]        dx_s, dy_s, dz_s, dx_a, dy_a, dz_a;
  logic               far, kind_ok;

  assign out_free = !result_valid || result_ready;
  assign pop      = (state == S_IDLE) && q_valid && out_free;
  assign q_pop    = pop;
  assign full     = (count == CW'(MAX_ATOMS));
  assign ram_we   = pop && (q_cmd.cls == pde_pkg::CLS_LOAD) && !full;
  assign idx_inc  = idx + CW'(1);

  pde_ram #(.WIDTH(EW), .DEPTH(MAX_ATOMS), .AW(AW)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[AW-1:0]),
    .wdata ({q_cmd.kind, q_cmd.x, q_cmd.y, q_cmd.z}),
    .re    (state == S_FETCH),
    .raddr (idx[AW-1:0]),
    .rdata (rdata)
  );

  // offsets from the fetched atom
  assign rd_kind = rdata[100:96];
  assign dx_s    = {px[31], px} - {rdata[95], rdata[95:64]};
  assign dy_s    = {py[31], py} - {rdata[63], rdata[63:32]};
  assign dz_s    = {pz[31], pz} - {rdata[31], rdata[31:0]};
  assign dx_a    = dx_s[32] ? (~dx_s + 33'd1) : dx_s;
  assign dy_a    = dy_s[32] ? (~dy_s + 33'd1) : dy_s;
  assign dz_a    = dz_s[32] ? (~dz_s + 33'd1) : dz_s;
  assign far     = (|dx_a[32:22]) || (|dy_a[32:22]) || (|dz_a[32:22]);
  assign kind_ok = (rd_kind != 5'd0) && (rd_kind < pde_pkg::ELEM_N);

  // digit-by-digit square root step
  assign root_sum = root_res + root_bit;
  assign root_ge  = (root_v >= root_sum);
  assign res_next = root_ge ? ((root_res >> 1) + root_bit) : (root_res >> 1);

  assign aq = pde_pkg::A_TAB[j][kind_r][29:0];
  assign cq = pde_pkg::C_TAB[j][kind_r][38:0];

  // reciprocal quotient is low by at most one
  assign q0      = prod[64:32];
  assign qk      = 33'(q0 * {29'd0, kk});
  assign rem     = xq - qk;
  assign qv      = (rem >= {29'd0, kk}) ? (q0 + 33'd1) : q0;
  assign sum_upd = kk[0] ? (sum - $signed({2'b00, qv})) : (sum + $signed({2'b00, qv}));

  always_comb begin
    if (sum[34]) begin
      e_clamp = 33'd0;
    end else if (sum > 35'sh1_0000_0000) begin
      e_clamp = 33'h1_0000_0000;
    end else begin
      e_clamp = sum[32:0];
    end
  end

  assign csum    = {1'b0, prod[43:0], 20'd0} + {20'd0, lo};
  assign acc_add = acc + {8'd0, csum[64:24]};

  always_comb begin
    case (sq_cnt)
      2'd0:    dsel = d0;
      2'd1:    dsel = d1;
      default: dsel = d2;
    endcase
  end

  always_comb begin
    case (state)
      S_SQ: begin
        mul_a = {11'd0, dsel};
        mul_b = {11'd0, dsel};
      end
      S_TPROD: begin
        mul_a = {3'd0, aq};
        mul_b = {10'd0, r};
      end
      S_TMUL: begin
        mul_a = term;
        mul_b = {1'b0, f};
      end
      S_TREC: begin
        mul_a = prod[64:32];
        mul_b = pde_pkg::RECIP[kk];
      end
      S_SCALE: begin
        mul_a = e;
        mul_b = {2'd0, pde_pkg::INV_E};
      end
      S_CLO: begin
        mul_a = {8'd0, e[32:8]};
        mul_b = {13'd0, cq[19:0]};
      end
      S_CHI: begin
        mul_a = {8'd0, e[32:8]};
        mul_b = {14'd0, cq[38:20]};
      end
      default: begin
        mul_a = 33'd0;
        mul_b = 33'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= {33'd0, mul_a} * {33'd0, mul_b};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop) begin
            rho <= 48'd0;
            status <= pde_pkg::ST_OK;
            case (q_cmd.cls)
              pde_pkg::CLS_CLEAR: begin
                count <= '0;
                result_valid <= 1'b1;
              end
              pde_pkg::CLS_LOAD: begin
                if (full) begin
                  status <= pde_pkg::ST_FULL;
                end else begin
                  count <= count + CW'(1);
                end
                result_valid <= 1'b1;
              end
              pde_pkg::CLS_EVAL: begin
                if (count == '0) begin
                  result_valid <= 1'b1;
                end else begin
                  idx   <= '0;
                  acc   <= '0;
                  sat   <= 1'b0;
                  px    <= q_cmd.x;
                  py    <= q_cmd.y;
                  pz    <= q_cmd.z;
                  state <= S_FETCH;
                end
              end
              default: begin
                result_valid <= 1'b1;
              end
            endcase
          end
        end
        S_FETCH: state <= S_DIFF;
        S_DIFF: begin
          if (!kind_ok || far) begin
            state <= S_NEXT;
          end else begin
            kind_r <= rd_kind;
            d0     <= dx_a[21:0];
            d1     <= dy_a[21:0];
            d2     <= dz_a[21:0];
            sq_cnt <= 2'd0;
            state  <= S_SQ;
          end
        end
        S_SQ: begin
          sq_cnt <= sq_cnt + 2'd1;
          case (sq_cnt)
            2'd0: r2 <= '0;
            2'd3: begin
              root_v   <= r2 + {2'd0, prod[43:0]};
              root_res <= '0;
              root_bit <= 46'd1 << 44;
              state    <= S_ROOT;
            end
            default: r2 <= r2 + {2'd0, prod[43:0]};
          endcase
        end
        S_ROOT: begin
          if (root_ge) begin
            root_v <= root_v - root_sum;
          end
          root_res <= res_next;
          root_bit <= root_bit >> 2;
          if (root_bit == 46'd1) begin
            r     <= res_next[22:0];
            j     <= 2'd0;
            state <= S_TPROD;
          end
        end
        S_TPROD: state <= S_TCHK;
        S_TCHK: begin
          // exponent of 64 or more gives nothing
          if (|prod[65:46]) begin
            if (j == 2'd2) begin
              state <= S_NEXT;
            end else begin
              j     <= j + 2'd1;
              state <= S_TPROD;
            end
          end else begin
            n     <= prod[45:40];
            f     <= prod[39:8];
            term  <= 33'h1_0000_0000;
            sum   <= 35'sh1_0000_0000;
            kk    <= 4'd1;
            state <= S_TMUL;
          end
        end
        S_TMUL: state <= S_TREC;
        S_TREC: begin
          xq    <= prod[64:32];
          state <= S_TCOR;
        end
        S_TCOR: begin
          term <= qv;
          sum  <= sum_upd;
          if (kk == 4'd14) begin
            state <= S_CLAMP;
          end else begin
            kk    <= kk + 4'd1;
            state <= S_TMUL;
          end
        end
        S_CLAMP: begin
          e     <= e_clamp;
          state <= (n == 6'd0) ? S_CLO : S_SCALE;
        end
        S_SCALE: state <= S_SHIFT;
        S_SHIFT: begin
          e     <= prod[64:32];
          n     <= n - 6'd1;
          state <= (n == 6'd1) ? S_CLO : S_SCALE;
        end
        S_CLO: state <= S_CHI;
        S_CHI: begin
          lo    <= prod[44:0];
          state <= S_CADD;
        end
        S_CADD: begin
          acc <= acc_add;
          if (j == 2'd2) begin
            state <= S_NEXT;
          end else begin
            j     <= j + 2'd1;
            state <= S_TPROD;
          end
        end
        S_NEXT: begin
          if (acc > {1'b0, pde_pkg::RHO_MAX}) begin
            acc <= {1'b0, pde_pkg::RHO_MAX};
            sat <= 1'b1;
          end
          if (idx_inc == count) begin
            state <= S_DONE;
          end else begin
            idx   <= idx_inc;
            state <= S_FETCH;
          end
        end
        S_DONE: begin
          if (out_free) begin
            result_valid <= 1'b1;
            rho          <= acc[47:0];
            status       <= sat ? pde_pkg::ST_SAT : pde_pkg::ST_OK;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PDE_ASSERT_ALWAYS(a_count_bound, count <= CW'(MAX_ATOMS), "atom count above store size")
  `PDE_ASSERT_IMPLY(a_fetch_range, state == S_FETCH, idx < count, "fetch beyond loaded atoms")
  `PDE_ASSERT_IMPLY(a_series_k, state == S_TCOR, (kk != 4'd0) && (kk <= 4'd14), "bad series divisor")
  `PDE_ASSERT_IMPLY(a_scale_n, state == S_SHIFT, n != 6'd0, "scale step with zero count")
  `PDE_ASSERT_IMPLY(a_sat_value, result_valid && (status == pde_pkg::ST_SAT), rho == pde_pkg::RHO_MAX, "saturated item without full-scale density")

endmodule

`default_nettype wire

/* src/promolecular_density_eval.sv */
// ----------------------------------------------------------------------------
// promolecular_density_eval
// atom store with three-term slater density sum at a query point
// ----------------------------------------------------------------------------
// clear, load and unknown actions: result valid is registered at the pop.
// evaluate: walks the loaded atoms in turn, skips an unknown kind or far atom,
// else takes the distance, then per term the series and a scale step per unit
// of exponent, on one shared 33x33 multiplier and the single store read port.
// two commands queue ahead of the sequencer. reset empties the store at once.
`timescale 1ns / 1ps
`default_nettype none

module promolecular_density_eval #(
  parameter int MAX_ATOMS = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output logic                    item_ready,
  input  wire logic [1:0]         action,
  input  wire logic [4:0]         atomic_number,
  input  wire logic signed [31:0] pos_x,
  input  wire logic signed [31:0] pos_y,
  input  wire logic signed [31:0] pos_z,
  output logic                    result_valid,
  input  wire logic               result_ready,
  output logic [47:0]             rho,
  output logic [1:0]              status
);

  logic          q_valid;
  logic          q_pop;
  pde_pkg::cmd_t q_cmd;

  pde_front u_front (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .action        (action),
    .atomic_number (atomic_number),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .pos_z         (pos_z),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .q_pop         (q_pop)
  );

  pde_back #(.MAX_ATOMS(MAX_ATOMS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .rho          (rho),
    .status       (status)
  );

endmodule

`default_nettype wire

/* test/promolecular_density_checker.sv */
// ----------------------------------------------------------------------------
// promolecular density checker
// watches both channels, keeps its own copy of the atom store, predicts the
// three-term slater density for every evaluate item and compares each result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module promolecular_density_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  input  wire logic        item_ready,
  input  wire logic [1:0]  action,
  input  wire logic [4:0]  atomic_number,
  input  wire logic [31:0] pos_x,
  input  wire logic [31:0] pos_y,
  input  wire logic [31:0] pos_z,
  input  wire logic        result_valid,
  input  wire logic        result_ready,
  input  wire logic [47:0] rho,
  input  wire logic [1:0]  status,
  output int               errors,
  output int               pending
);

  localparam int STORE_DEPTH = 256;
  localparam int ELEMENTS = 19;
  localparam logic [63:0] FAR_DIST = 64'd1 << 22;
  localparam logic [63:0] INV_E_Q32 = 64'd1580030169;
  localparam logic [63:0] DENSITY_MAX = 64'hFFFF_FFFF_FFFF;

  // slater coefficients and exponents, mantissa m.mmmmmmm and decimal exponent
  localparam int unsigned COEF_MANT [0:2][0:18] = '{
    '{0, 46568633, 19613583, 10682467, 49307260, 25663419, 40348178, 63406713,
      95831026, 16273443, 19788394, 35289679, 10046303, 62991738, 84532518,
      11107832, 14348550, 60301596, 80816108},
    '{0, 46568622, 19568763, 10681231, 52439107, 11256576, 22620806, 63404543,
      89583281, 13870221, 19614363, 35302178, 45960222, 15274864, 84342635,
      31824165, 44165626, 18325620, 23005524},
    '{0, 30019989, 13983775, 33342545, 31734662, 25867085, 40837497, 46765606,
      95832030, 14029674, 28279579, 74670217, 46015044, 62957609, 22368762,
      11103799, 14364194, 18305210, 23084071}};
  localparam int COEF_EXP [0:2][0:18] = '{
    '{0, -1, 1, 2, -1, 2, 2, 2, 2, 1, 3, 3, 2, 3, 3, 4, 4, 2, 2},
    '{0, -1, 1, 2, 0, 0, 0, 2, 0, 3, 3, 3, 3, 2, 3, 2, 2, 4, 4},
    '{0, 0, 0, 1, 2, 2, 2, 0, 2, 3, 1, 1, 3, 3, 2, 4, 4, 4, 4}};
  localparam int unsigned DECAY_MANT [0:2][0:18] = '{
    '{0, 19888088, 38987496, 62028021, 72657186, 97173881, 11698438, 13677050,
      15655698, 15948420, 19625025, 22086110, 26605426, 26057308, 28120183,
      30186892, 32254026, 42979610, 46484753},
    '{0, 19888088, 38982540, 62023193, 41739221, 83058204, 96295177, 13677045,
      13642293, 17635609, 19625014, 22085863, 23998338, 29772425, 28120238,
      36228839, 39540388, 34332866, 36415201},
    '{0, 19888228, 16012664, 38061318, 78497277, 97173599, 11698438, 11538421,
      15655807, 17635595, 18462843, 24886290, 23998352, 26057363, 32971353,
      30186664, 32254046, 34332897, 36415230}};
  localparam int DECAY_EXP [0:2][0:18] = '{
    '{0, 0, 0, 0, -1, 0, 1, 1, 1, 0, 1, 1, 0, 1, 1, 1, 1, 0, 0},
    '{0, 0, 0, 0, 0, -1, -1, 1, 0, 1, 1, 1, 1, 0, 1, 0, 0, 1, 1},
    '{0, 0, 0, 0, 0, 0, 1, 0, 1, 1, 0, 0, 1, 1, 0, 1, 1, 1, 1}};

  typedef struct packed {
    logic [47:0] rho;
    logic [1:0]  status;
  } density_result_t;

  logic [4:0]  atom_kind [STORE_DEPTH];
  logic [31:0] atom_x [STORE_DEPTH];
  logic [31:0] atom_y [STORE_DEPTH];
  logic [31:0] atom_z [STORE_DEPTH];
  int          atom_count;
  density_result_t expected_results [$];

  function automatic logic [63:0] decimal_to_q24(int unsigned mant, int ex);
    logic [63:0] div;
    int digits;
    div = 64'd1;
    digits = 7 - ex;
    repeat (digits) div = div * 64'd10;
    return ((64'(mant) << 24) + div / 2) / div;
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] root, trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // exp(-t) in q32 for t in q40
  function automatic logic [63:0] decay_q32(logic [63:0] t);
    logic [63:0] whole, frac, term, e;
    longint acc;
    if (t >= (64'd64 << 40)) return 64'd0;
    whole = t >> 40;
    frac = (t >> 8) & 64'hFFFF_FFFF;
    term = 64'd1 << 32;
    acc = longint'(64'd1 << 32);
    for (int k = 1; k <= 14; k++) begin
      term = ((term * frac) >> 32) / 64'(k);
      if (k % 2 == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    if (acc > longint'(64'd1 << 32)) acc = longint'(64'd1 << 32);
    e = 64'(acc);
    repeat (whole) e = (e * INV_E_Q32) >> 32;
    return e;
  endfunction

  function automatic logic [63:0] abs_diff(logic [31:0] a, logic [31:0] b);
    longint d;
    d = longint'($signed(a)) - longint'($signed(b));
    return (d < 0) ? 64'(-d) : 64'(d);
  endfunction

  function automatic density_result_t density_at(logic [31:0] px, logic [31:0] py,
                                                 logic [31:0] pz);
    density_result_t res;
    logic [63:0] acc, dx, dy, dz, r;
    int el;
    logic saturated;
    acc = 0;
    saturated = 0;
    for (int i = 0; i < atom_count; i++) begin
      el = atom_kind[i];
      if (el == 0 || el >= ELEMENTS) continue;
      dx = abs_diff(px, atom_x[i]);
      dy = abs_diff(py, atom_y[i]);
      dz = abs_diff(pz, atom_z[i]);
      if (dx >= FAR_DIST || dy >= FAR_DIST || dz >= FAR_DIST) continue;
      r = floor_sqrt(dx * dx + dy * dy + dz * dz);
      for (int j = 0; j < 3; j++) begin
        acc = acc + ((decimal_to_q24(COEF_MANT[j][el], COEF_EXP[j][el]) *
               (decay_q32(decimal_to_q24(DECAY_MANT[j][el], DECAY_EXP[j][el]) * r) >> 8))
               >> 24);
      end
      if (acc > DENSITY_MAX) begin
        acc = DENSITY_MAX;
        saturated = 1;
      end
    end
    res.rho = acc[47:0];
    res.status = saturated ? pde_pkg::ST_SAT : pde_pkg::ST_OK;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch: %s got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    density_result_t res, want;
    if (!rst) begin
      if (item_valid && item_ready) begin
        res = '{rho: 48'd0, status: pde_pkg::ST_OK};
        case (action)
          pde_pkg::ACT_CLEAR: atom_count = 0;
          pde_pkg::ACT_LOAD: begin
            if (atom_count < STORE_DEPTH) begin
              atom_kind[atom_count] = atomic_number;
              atom_x[atom_count] = pos_x;
              atom_y[atom_count] = pos_y;
              atom_z[atom_count] = pos_z;
              atom_count++;
            end else begin
              res.status = pde_pkg::ST_FULL;
            end
          end
          pde_pkg::ACT_EVAL: res = density_at(pos_x, pos_y, pos_z);
          default: ;
        endcase
        expected_results = {expected_results, res};
      end
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with no item pending", {rho, status}, 0);
        end else begin
          want = expected_results.pop_front();
          if (rho !== want.rho) report_mismatch("rho", rho, want.rho);
          if (status !== want.status) report_mismatch("status", status, want.status);
        end
      end
      pending = expected_results.size();
    end
  end

endmodule

/* test/promolecular_density_eval_tb.sv */
// ----------------------------------------------------------------------------
// promolecular_density_eval_tb
// drives clear, load, evaluate and unknown items with random gaps and stalls;
// a side checker predicts every result and counts mismatches
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module promolecular_density_eval_tb;

  localparam logic [1:0] ACT_NOP = 2'd3;
  localparam int RANDOM_ITEMS = 1900;
  localparam longint CYCLE_LIMIT = 40000000;

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_ready;
  logic [1:0]  action;
  logic [4:0]  atomic_number;
  logic [31:0] pos_x, pos_y, pos_z;
  logic        result_valid;
  logic        result_ready;
  logic [47:0] rho;
  logic [1:0]  status;
  int          errors, pending;
  longint      cycles;
  bit          idle_on;
  int          stored_atoms;
  int          sent_items;

  promolecular_density_eval dut (
    .clk, .rst, .item_valid, .item_ready, .action, .atomic_number,
    .pos_x, .pos_y, .pos_z, .result_valid, .result_ready, .rho, .status
  );

  promolecular_density_checker density_check (
    .clk, .rst, .item_valid, .item_ready, .action, .atomic_number,
    .pos_x, .pos_y, .pos_z, .result_valid, .result_ready, .rho, .status,
    .errors, .pending
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_item(logic [1:0] act, logic [4:0] kind, logic [31:0] x,
                           logic [31:0] y, logic [31:0] z);
    int gap;
    gap = idle_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      @(negedge clk) item_valid <= 0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    item_valid <= 1;
    action <= act;
    atomic_number <= kind;
    pos_x <= x;
    pos_y <= y;
    pos_z <= z;
    do @(posedge clk); while (!(item_valid && item_ready));
    sent_items++;
    if (act == pde_pkg::ACT_CLEAR) stored_atoms = 0;
    else if (act == pde_pkg::ACT_LOAD && stored_atoms < 256) stored_atoms++;
  endtask

  task automatic drain();
    @(negedge clk) item_valid <= 0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] near(logic [31:0] base, int span);
    return base + 32'($urandom_range(0, 2 * span)) - 32'(span);
  endfunction

  // result side stalls independently of the sender
  initial begin
    int stall;
    result_ready = 0;
    @(negedge rst);
    forever begin
      stall = idle_on ? $urandom_range(0, 10) : 0;
      repeat (stall) @(negedge clk) result_ready <= 0;
      @(negedge clk) result_ready <= 1;
      do @(posedge clk); while (!(result_valid && result_ready));
    end
  end

  initial begin
    logic [31:0] bx, by, bz;
    logic [4:0] kind;
    int loads, evals;
    rst = 1;
    item_valid = 0;
    action = pde_pkg::ACT_CLEAR;
    atomic_number = 0;
    pos_x = 0;
    pos_y = 0;
    pos_z = 0;
    idle_on = 1;
    stored_atoms = 0;
    sent_items = 0;
    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 0;

    // directed: empty store, unknown kinds, extreme positions, distance limits
    send_item(pde_pkg::ACT_EVAL, 5'd0, 32'h0, 32'h0, 32'h0);
    send_item(ACT_NOP, 5'h1F, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(pde_pkg::ACT_LOAD, 5'd0, 32'h0, 32'h0, 32'h0);
    send_item(pde_pkg::ACT_LOAD, 5'd19, 32'h0, 32'h0, 32'h0);
    send_item(pde_pkg::ACT_LOAD, 5'h1F, 32'h0, 32'h0, 32'h0);
    send_item(pde_pkg::ACT_EVAL, 5'd0, 32'h0, 32'h0, 32'h0);
    send_item(pde_pkg::ACT_LOAD, 5'd1, 32'h0, 32'h0, 32'h0);
    send_item(pde_pkg::ACT_LOAD, 5'd18, 32'h0001_0000, 32'hFFFF_0000, 32'h0);
    send_item(pde_pkg::ACT_EVAL, 5'd0, 32'h0, 32'h0, 32'h0);
    send_item(pde_pkg::ACT_EVAL, 5'd0, 32'h003F_FFFF, 32'h0, 32'h0);
    send_item(pde_pkg::ACT_EVAL, 5'd0, 32'h0040_0000, 32'h0, 32'h0);
    send_item(pde_pkg::ACT_EVAL, 5'd0, 32'h0, 32'hFFC0_0001, 32'h0);
    send_item(pde_pkg::ACT_EVAL, 5'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_item(pde_pkg::ACT_CLEAR, 5'd0, 32'h0, 32'h0, 32'h0);
    send_item(pde_pkg::ACT_LOAD, 5'd10, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(pde_pkg::ACT_LOAD, 5'd16, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_item(pde_pkg::ACT_EVAL, 5'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(pde_pkg::ACT_EVAL, 5'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_item(pde_pkg::ACT_EVAL, 5'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);

    // full store: a dropped load, then heaviest density at one point
    send_item(pde_pkg::ACT_CLEAR, 5'd0, 32'h0, 32'h0, 32'h0);
    repeat (256) send_item(pde_pkg::ACT_LOAD, 5'd18, 32'h0, 32'h0, 32'h0);
    send_item(pde_pkg::ACT_LOAD, 5'd17, 32'h0, 32'h0, 32'h0);
    send_item(pde_pkg::ACT_EVAL, 5'd0, 32'h0, 32'h0, 32'h0);
    send_item(pde_pkg::ACT_EVAL, 5'd0, 32'h0000_8000, 32'h0, 32'hFFFF_8000);

    // random sequences: clear, a few loads mostly around a center, evals mostly nearby
    while (sent_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 7) == 0) idle_on = !idle_on;
      if (sent_items > 900 && sent_items < 912) drain();
      bx = 32'($urandom_range(0, 32'h0100_0000)) - 32'h0080_0000;
      by = 32'($urandom_range(0, 32'h0100_0000)) - 32'h0080_0000;
      bz = 32'($urandom_range(0, 32'h0100_0000)) - 32'h0080_0000;
      if (stored_atoms > 6 || $urandom_range(0, 3) != 0)
        send_item(pde_pkg::ACT_CLEAR, 5'($urandom), $urandom, $urandom, $urandom);
      loads = $urandom_range(0, 4);
      for (int i = 0; i < loads; i++) begin
        kind = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(1, 18));
        if ($urandom_range(0, 11) == 0)
          send_item(pde_pkg::ACT_LOAD, kind, $urandom, $urandom, $urandom);
        else
          send_item(pde_pkg::ACT_LOAD, kind, near(bx, 1 << 18), near(by, 1 << 18),
                    near(bz, 1 << 18));
      end
      evals = $urandom_range(1, 3);
      for (int i = 0; i < evals; i++) begin
        case ($urandom_range(0, 15))
          0: send_item(pde_pkg::ACT_EVAL, 5'($urandom), $urandom, $urandom, $urandom);
          1: send_item(ACT_NOP, 5'($urandom), $urandom, $urandom, $urandom);
          2: send_item(pde_pkg::ACT_EVAL, 5'($urandom), near(bx, 1 << 21),
                       near(by, 1 << 21), near(bz, 1 << 21));
          default: send_item(pde_pkg::ACT_EVAL, 5'($urandom), near(bx, 1 << 17),
                             near(by, 1 << 17), near(bz, 1 << 17));
        endcase
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
